### rtl/obb_pkg.sv
// Package for the oriented-box pair collision block.
// Holds payload structs, the quarter-wave sine table and axis codes; no dependencies.
package obb_pkg;

    localparam int POS_W = 24;
    localparam int ANG_W = 16;
    localparam int SIZE_W = 16;
    localparam int PEN_W = 40;

    localparam logic [2:0] AXIS_AY   = 3'd0;
    localparam logic [2:0] AXIS_AX   = 3'd1;
    localparam logic [2:0] AXIS_BY   = 3'd2;
    localparam logic [2:0] AXIS_BX   = 3'd3;
    localparam logic [2:0] AXIS_NONE = 3'd4;

    typedef struct packed {
        logic signed [POS_W-1:0] a_center_x;
        logic signed [POS_W-1:0] a_center_y;
        logic [ANG_W-1:0]        a_heading;
        logic [SIZE_W-1:0]       a_width;
        logic [SIZE_W-1:0]       a_length;
        logic signed [POS_W-1:0] b_center_x;
        logic signed [POS_W-1:0] b_center_y;
        logic [ANG_W-1:0]        b_heading;
        logic [SIZE_W-1:0]       b_width;
        logic [SIZE_W-1:0]       b_length;
    } obb_in_t;

    typedef struct packed {
        logic             overlap;
        logic [2:0]       separating_axis;
        logic [PEN_W-1:0] penetration_sq;
    } obb_out_t;

    // Quarter-wave sine, round(32767*sin(k*pi/128)), k = 0..64
    function automatic logic [15:0] qtab(input logic [6:0] k);
        logic [15:0] v;
        case (k)
            7'd0: v = 16'd0;      7'd1: v = 16'd804;    7'd2: v = 16'd1608;
            7'd3: v = 16'd2410;   7'd4: v = 16'd3212;   7'd5: v = 16'd4011;
            7'd6: v = 16'd4808;   7'd7: v = 16'd5602;   7'd8: v = 16'd6393;
            7'd9: v = 16'd7179;   7'd10: v = 16'd7962;  7'd11: v = 16'd8739;
            7'd12: v = 16'd9512;  7'd13: v = 16'd10278; 7'd14: v = 16'd11039;
            7'd15: v = 16'd11793; 7'd16: v = 16'd12539; 7'd17: v = 16'd13279;
            7'd18: v = 16'd14010; 7'd19: v = 16'd14732; 7'd20: v = 16'd15446;
            7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17530;
            7'd24: v = 16'd18204; 7'd25: v = 16'd18868; 7'd26: v = 16'd19519;
            7'd27: v = 16'd20159; 7'd28: v = 16'd20787; 7'd29: v = 16'd21403;
            7'd30: v = 16'd22005; 7'd31: v = 16'd22594; 7'd32: v = 16'd23170;
            7'd33: v = 16'd23732; 7'd34: v = 16'd24279; 7'd35: v = 16'd24811;
            7'd36: v = 16'd25329; 7'd37: v = 16'd25832; 7'd38: v = 16'd26319;
            7'd39: v = 16'd26790; 7'd40: v = 16'd27245; 7'd41: v = 16'd27683;
            7'd42: v = 16'd28105; 7'd43: v = 16'd28510; 7'd44: v = 16'd28898;
            7'd45: v = 16'd29268; 7'd46: v = 16'd29621; 7'd47: v = 16'd29956;
            7'd48: v = 16'd30273; 7'd49: v = 16'd30571; 7'd50: v = 16'd30852;
            7'd51: v = 16'd31113; 7'd52: v = 16'd31356; 7'd53: v = 16'd31580;
            7'd54: v = 16'd31785; 7'd55: v = 16'd31971; 7'd56: v = 16'd32137;
            7'd57: v = 16'd32285; 7'd58: v = 16'd32412; 7'd59: v = 16'd32521;
            7'd60: v = 16'd32609; 7'd61: v = 16'd32678; 7'd62: v = 16'd32728;
            7'd63: v = 16'd32757; 7'd64: v = 16'd32767;
            default: v = 16'd32767;
        endcase
        return v;
    endfunction

endpackage

### rtl/obb_sincos.sv
// Pipelined sine/cosine of one heading: table lookup, then interpolation and quadrant signs.
// Depends on obb_pkg for the quarter-wave table. Table entries are registered, then the signed results; advances on en.
module obb_sincos import obb_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] heading,
    output logic signed [16:0]    sin_q,
    output logic signed [16:0]    cos_q
);
    localparam int FRAC_BITS = ANGLE_BITS - 8;
    localparam int PB = ANGLE_BITS - 2;

    logic [1:0]           quad;
    logic [PB-1:0]        p;
    logic [PB:0]          pc;
    logic [15:0]          slo, shi, clo, chi;
    logic [FRAC_BITS-1:0] sf, cf;

    logic [15:0]          slo_reg, sdiff_reg, clo_reg, cdiff_reg;
    logic [FRAC_BITS-1:0] sf_reg, cf_reg;
    logic [1:0]           quad_reg;

    logic [15+FRAC_BITS:0] sprod, cprod;
    logic signed [16:0]    qs, qc;
    logic signed [16:0]    sin_next, cos_next;
    logic signed [16:0]    sin_reg, cos_reg;

    // Split angle into quadrant and phase; fetch neighboring table entries
    always_comb
    begin
        quad = heading[ANGLE_BITS-1 -: 2];
        p    = heading[PB-1:0];
        pc   = (PB+1)'(1) << PB;
        pc   = pc - {1'b0, p};
        slo  = qtab({1'b0, p[PB-1 -: 6]});
        shi  = qtab({1'b0, p[PB-1 -: 6]} + 7'd1);
        sf   = p[FRAC_BITS-1:0];
        if (pc[PB])
        begin
            clo = qtab(7'd64);
            chi = qtab(7'd64);
            cf  = '0;
        end
        else
        begin
            clo = qtab({1'b0, pc[PB-1 -: 6]});
            chi = qtab({1'b0, pc[PB-1 -: 6]} + 7'd1);
            cf  = pc[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slo_reg   <= slo;
            sdiff_reg <= shi - slo;
            sf_reg    <= sf;
            clo_reg   <= clo;
            cdiff_reg <= chi - clo;
            cf_reg    <= cf;
            quad_reg  <= quad;
        end
    end

    // Interpolate, truncating, then apply quadrant signs
    always_comb
    begin
        sprod = sdiff_reg * sf_reg;
        cprod = cdiff_reg * cf_reg;
        qs = signed'({1'b0, slo_reg + 16'(sprod >> FRAC_BITS)});
        qc = signed'({1'b0, clo_reg + 16'(cprod >> FRAC_BITS)});
        case (quad_reg)
            2'd0:    begin sin_next = qs;  cos_next = qc;  end
            2'd1:    begin sin_next = qc;  cos_next = -qs; end
            2'd2:    begin sin_next = -qs; cos_next = -qc; end
            default: begin sin_next = -qc; cos_next = qs;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

### rtl/obb_pair_collision_sat.sv
// Oriented-box pair separating-axis test: one box pair per cycle while the output is not stalled.
// Stages: sin/cos table (2), dot products and projections, radii, compare and margins,
// squares and saturation. The whole pipe advances when its output register is free
// or being taken, so a stall holds every stage; throughput is one transaction per clock.
// Depends on obb_pkg and obb_sincos.
module obb_pair_collision_sat import obb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  obb_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output obb_out_t out_data
);
    localparam int ANGLE_BITS    = ANG_W;
    localparam int POSITION_BITS = POS_W;
    localparam int NST = 6;
    localparam int TW  = POSITION_BITS + 1;

    logic            adv;
    logic [NST-1:0]  vld_reg, vld_next;

    // Pipeline advances unless the last stage holds an untaken result
    assign adv      = !vld_reg[NST-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[NST-1];

    always_comb
    begin
        vld_next = {vld_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Stage 1-2: headings through sin/cos; center offset and sizes ride along
    logic signed [16:0] sa, ca, sb, cb;
    logic signed [TW-1:0] tx1_reg, ty1_reg, tx2_reg, ty2_reg;
    logic [15:0] wa1_reg, la1_reg, wb1_reg, lb1_reg;
    logic [15:0] wa2_reg, la2_reg, wb2_reg, lb2_reg;
    logic signed [POSITION_BITS-1:0] axp, ayp, bxp, byp;

    obb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_a (
        .clk(clk), .en(adv), .heading(in_data.a_heading[ANGLE_BITS-1:0]),
        .sin_q(sa), .cos_q(ca));
    obb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_b (
        .clk(clk), .en(adv), .heading(in_data.b_heading[ANGLE_BITS-1:0]),
        .sin_q(sb), .cos_q(cb));

    always_comb
    begin
        axp = in_data.a_center_x[POSITION_BITS-1:0];
        ayp = in_data.a_center_y[POSITION_BITS-1:0];
        bxp = in_data.b_center_x[POSITION_BITS-1:0];
        byp = in_data.b_center_y[POSITION_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx1_reg <= TW'(bxp) - TW'(axp);
            ty1_reg <= TW'(byp) - TW'(ayp);
            wa1_reg <= in_data.a_width;
            la1_reg <= in_data.a_length;
            wb1_reg <= in_data.b_width;
            lb1_reg <= in_data.b_length;
            tx2_reg <= tx1_reg;
            ty2_reg <= ty1_reg;
            wa2_reg <= wa1_reg;
            la2_reg <= la1_reg;
            wb2_reg <= wb1_reg;
            lb2_reg <= lb1_reg;
        end
    end

    // Stage 3: axis dot products (rounded Q15) and the four center projections
    localparam int PW = TW + 18;
    logic signed [35:0] dc, ds;
    logic [35:0] dcm, dsm;
    logic signed [PW-1:0] q0, q1, q2, q3;
    logic [16:0] kc3_reg, ks3_reg;
    logic [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [15:0] wa3_reg, la3_reg, wb3_reg, lb3_reg;

    function automatic logic [PW-1:0] pmag(input logic signed [PW-1:0] v);
        return v[PW-1] ? PW'(-v) : PW'(v);
    endfunction

    always_comb
    begin
        dc  = 36'(ca * cb) + 36'(sa * sb);
        ds  = 36'(sa * cb) - 36'(ca * sb);
        dcm = dc[35] ? 36'(-dc) : 36'(dc);
        dsm = ds[35] ? 36'(-ds) : 36'(ds);
        q0  = PW'(tx2_reg * ca) + PW'(ty2_reg * sa);
        q1  = PW'(tx2_reg * sa) - PW'(ty2_reg * ca);
        q2  = PW'(tx2_reg * cb) + PW'(ty2_reg * sb);
        q3  = PW'(tx2_reg * sb) - PW'(ty2_reg * cb);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kc3_reg <= 17'((dcm + 36'd16384) >> 15);
            ks3_reg <= 17'((dsm + 36'd16384) >> 15);
            p0_reg  <= pmag(q0);
            p1_reg  <= pmag(q1);
            p2_reg  <= pmag(q2);
            p3_reg  <= pmag(q3);
            wa3_reg <= wa2_reg;
            la3_reg <= la2_reg;
            wb3_reg <= wb2_reg;
            lb3_reg <= lb2_reg;
        end
    end

    // Stage 4: radii in the doubled-projection scale
    localparam int RW = 35;
    logic [RW-1:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [PW-1:0] p0_4_reg, p1_4_reg, p2_4_reg, p3_4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg <= (RW'(la3_reg) << 15) + RW'(wb3_reg * ks3_reg) + RW'(lb3_reg * kc3_reg);
            r1_reg <= (RW'(wa3_reg) << 15) + RW'(wb3_reg * kc3_reg) + RW'(lb3_reg * ks3_reg);
            r2_reg <= (RW'(lb3_reg) << 15) + RW'(wa3_reg * ks3_reg) + RW'(la3_reg * kc3_reg);
            r3_reg <= (RW'(wb3_reg) << 15) + RW'(wa3_reg * kc3_reg) + RW'(la3_reg * ks3_reg);
            p0_4_reg <= p0_reg;
            p1_4_reg <= p1_reg;
            p2_4_reg <= p2_reg;
            p3_4_reg <= p3_reg;
        end
    end

    // Stage 5: compare (projection doubled), pick first separating axis, round margins
    localparam int CW = PW + 2;
    logic [CW-1:0] c0, c1, c2, c3;
    logic sep0, sep1, sep2, sep3;
    logic [2:0] axis5_next, axis5_reg;
    logic [CW-1:0] m0, m1;
    logic [23:0] e0_reg, e1_reg;

    always_comb
    begin
        c0 = CW'(p0_4_reg) << 1;
        c1 = CW'(p1_4_reg) << 1;
        c2 = CW'(p2_4_reg) << 1;
        c3 = CW'(p3_4_reg) << 1;
        sep0 = c0 > CW'(r0_reg);
        sep1 = c1 > CW'(r1_reg);
        sep2 = c2 > CW'(r2_reg);
        sep3 = c3 > CW'(r3_reg);
        if (sep0)      axis5_next = AXIS_AY;
        else if (sep1) axis5_next = AXIS_AX;
        else if (sep2) axis5_next = AXIS_BY;
        else if (sep3) axis5_next = AXIS_BX;
        else           axis5_next = AXIS_NONE;
        m0 = CW'(r0_reg) - c0 + CW'(2048);
        m1 = CW'(r1_reg) - c1 + CW'(2048);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            axis5_reg <= axis5_next;
            e0_reg    <= 24'(m0 >> 12);
            e1_reg    <= 24'(m1 >> 12);
        end
    end

    // Stage 6: square margins, saturate, zero when separated
    logic [48:0] pen;
    obb_out_t out_next, out_reg;

    always_comb
    begin
        pen = 49'(e0_reg * e0_reg) + 49'(e1_reg * e1_reg);
        out_next.overlap         = (axis5_reg == AXIS_NONE);
        out_next.separating_axis = axis5_reg;
        if (axis5_reg != AXIS_NONE)
            out_next.penetration_sq = '0;
        else if (pen[48:PEN_W] != '0)
            out_next.penetration_sq = '1;
        else
            out_next.penetration_sq = pen[PEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_ovl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.overlap == (out_data.separating_axis == AXIS_NONE)))
        else $error("overlap flag disagrees with axis");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.overlap |-> out_data.penetration_sq == '0)
        else $error("separated pair has penetration");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted transaction lost");
`endif

endmodule

### sim/obb_pair_collision_sat_tb.sv
// Self-checking testbench for obb_pair_collision_sat: directed table, then random box pairs.
// Results are checked against an in-bench predictor of the separating-axis test.
// Depends on obb_pkg and the obb_pair_collision_sat RTL.
`timescale 1ns / 100ps

module obb_pair_collision_sat_tb;
    import obb_pkg::*;

    localparam int  RANDOM_ITEMS = 850;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  HOLD_AT      = 600;
    localparam int  HOLD_CYCLES  = 300;
    localparam longint unsigned PEN_SAT = 64'hFF_FFFF_FFFF;

    localparam int SINE_Q [0:64] = '{
            0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
         6393,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
        23170, 23732, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    obb_in_t  in_data;
    logic     out_valid;
    logic     out_ready = 1'b0;
    obb_out_t out_data;

    obb_out_t expected_hits[$];
    int       mismatches;
    int       sent;
    int       cycles = 0;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_done = 1'b0;
    int       hold_left = 0;

    obb_pair_collision_sat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Interpolated quarter-wave sine, Q1.15
    function automatic longint quarter_sine(input int unsigned p);
        int unsigned idx;
        int unsigned f;
        longint lo;
        longint hi;
        if (p >= 16384)
            return 32767;
        idx = p >> 8;
        f   = p & 255;
        lo  = SINE_Q[idx];
        hi  = SINE_Q[idx + 1];
        return lo + (((hi - lo) * f) >> 8);
    endfunction

    function automatic void heading_axes(input logic [15:0] h, output longint s,
                                         output longint c);
        int unsigned p;
        longint qs;
        longint qc;
        p  = h & 16'h3FFF;
        qs = quarter_sine(p);
        qc = quarter_sine(16384 - p);
        case (h[15:14])
            2'd0: begin s = qs;  c = qc;  end
            2'd1: begin s = qc;  c = -qs; end
            2'd2: begin s = -qs; c = -qc; end
            default: begin s = -qc; c = qs; end
        endcase
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned cross_cos(input longint ux, input longint uy,
                                                  input longint vx, input longint vy);
        return (abs64(ux * vx + uy * vy) + 16384) >> 15;
    endfunction

    function automatic longint unsigned offset_proj(input longint tx, input longint ty,
                                                    input longint ax, input longint ay);
        return abs64(tx * ax + ty * ay) << 1;
    endfunction

    function automatic longint unsigned margin_sq(input longint unsigned r,
                                                  input longint unsigned p);
        longint unsigned e;
        e = ((r - p) + 2048) >> 12;
        return e * e;
    endfunction

    // Predict one box-pair verdict
    function automatic obb_out_t predict_collision(input obb_in_t d);
        obb_out_t o;
        longint sa, ca, sb, cb, tx, ty;
        longint unsigned wa, la, wb, lb, kc, ks, pen;
        longint unsigned r0, p0, r1, p1, r2, p2, r3, p3;
        heading_axes(d.a_heading, sa, ca);
        heading_axes(d.b_heading, sb, cb);
        tx = longint'($signed(d.b_center_x)) - longint'($signed(d.a_center_x));
        ty = longint'($signed(d.b_center_y)) - longint'($signed(d.a_center_y));
        wa = d.a_width;
        la = d.a_length;
        wb = d.b_width;
        lb = d.b_length;
        kc = cross_cos(ca, sa, cb, sb);
        ks = cross_cos(sa, -ca, cb, sb);
        r0 = (la << 15) + wb * ks + lb * kc;
        p0 = offset_proj(tx, ty, ca, sa);
        r1 = (wa << 15) + wb * kc + lb * ks;
        p1 = offset_proj(tx, ty, sa, -ca);
        r2 = (lb << 15) + wa * ks + la * kc;
        p2 = offset_proj(tx, ty, cb, sb);
        r3 = (wb << 15) + wa * kc + la * ks;
        p3 = offset_proj(tx, ty, sb, -cb);
        o.overlap = 1'b0;
        o.penetration_sq = '0;
        if (p0 > r0)
            o.separating_axis = AXIS_AY;
        else if (p1 > r1)
            o.separating_axis = AXIS_AX;
        else if (p2 > r2)
            o.separating_axis = AXIS_BY;
        else if (p3 > r3)
            o.separating_axis = AXIS_BX;
        else
        begin
            pen = margin_sq(r0, p0) + margin_sq(r1, p1);
            if (pen > PEN_SAT)
                pen = PEN_SAT;
            o.overlap = 1'b1;
            o.separating_axis = AXIS_NONE;
            o.penetration_sq = pen[PEN_W-1:0];
        end
        return o;
    endfunction

    function automatic obb_in_t make_pair(input int ax, input int ay, input int ah,
                                          input int aw, input int al, input int bx,
                                          input int by, input int bh, input int bw,
                                          input int bl);
        obb_in_t d;
        d.a_center_x = ax[23:0];
        d.a_center_y = ay[23:0];
        d.a_heading  = ah[15:0];
        d.a_width    = aw[15:0];
        d.a_length   = al[15:0];
        d.b_center_x = bx[23:0];
        d.b_center_y = by[23:0];
        d.b_heading  = bh[15:0];
        d.b_width    = bw[15:0];
        d.b_length   = bl[15:0];
        return d;
    endfunction

    // Mostly near pairs so every axis test is reached; some fully random pairs
    function automatic obb_in_t random_pair();
        obb_in_t d;
        int ax, ay, span;
        if ($urandom_range(99) < 20)
        begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return d;
        end
        span = ($urandom_range(9) == 0) ? 65535 : 12000;
        ax = $urandom_range(8000000) - 4000000;
        ay = $urandom_range(8000000) - 4000000;
        return make_pair(ax, ay, $urandom_range(65535), $urandom_range(span),
                         $urandom_range(span), ax + $urandom_range(2 * span) - span,
                         ay + $urandom_range(2 * span) - span, $urandom_range(65535),
                         $urandom_range(span), $urandom_range(span));
    endfunction

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Hand one transaction to the block; log the expectation (typed row or prediction) on acceptance
    task automatic send_pair(input obb_in_t d, input bit typed, input obb_out_t typed_exp);
        obb_out_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        want = predict_collision(d);
        if (typed && want != typed_exp)
            report("typed row vs predictor", sent, sent);
        expected_hits.push_back(typed ? typed_exp : want);
        sent++;
        @(negedge clk);
    endtask

    // Receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!hold_done && sent >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        obb_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
                report("unexpected result", sent, 0);
            else
            begin
                want = expected_hits.pop_front();
                if (out_data.overlap != want.overlap)
                    report("overlap", out_data.overlap, want.overlap);
                if (out_data.separating_axis != want.separating_axis)
                    report("separating_axis", out_data.separating_axis,
                           want.separating_axis);
                if (out_data.penetration_sq != want.penetration_sq)
                    report("penetration_sq", out_data.penetration_sq,
                           want.penetration_sq);
            end
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        obb_in_t  rows[$];
        bit       typed[$];
        obb_out_t exps[$];
        obb_out_t none;
        int       spare;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        sent = 0;
        send_idle_pct = 36;
        recv_idle_pct = 47;
        none = '0;

        // Directed table; typed expectations only where obvious
        rows.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        typed.push_back(1); exps.push_back('{1'b1, AXIS_NONE, '0});
        rows.push_back(make_pair(-8388608, 0, 0, 0, 0, 8388607, 0, 0, 0, 0));
        typed.push_back(1); exps.push_back('{1'b0, AXIS_AY, '0});
        rows.push_back(make_pair(0, -8388608, 0, 0, 0, 0, 8388607, 0, 0, 0));
        typed.push_back(1); exps.push_back('{1'b0, AXIS_AX, '0});
        rows.push_back(make_pair(0, 0, 0, 65535, 65535, 0, 0, 0, 65535, 65535));
        typed.push_back(1); exps.push_back('{1'b1, AXIS_NONE, 40'hFF_FFFF_FFFF});
        // Touching along A's y axis: does not separate
        rows.push_back(make_pair(0, 0, 0, 256, 256, 256, 0, 0, 256, 256));
        typed.push_back(0); exps.push_back(none);
        rows.push_back(make_pair(0, 0, 0, 256, 256, 257, 0, 0, 256, 256));
        typed.push_back(0); exps.push_back(none);
        // Thin A rotated; B long along its own heading for the B-y test
        rows.push_back(make_pair(0, 0, 8192, 0, 40000, 3000, 30000, 57344, 100, 400));
        typed.push_back(0); exps.push_back(none);
        rows.push_back(make_pair(0, 0, 0, 2000, 2000, 2500, 2500, 8192, 200, 2000));
        typed.push_back(0); exps.push_back(none);
        rows.push_back(make_pair(0, 0, 0, 2000, 2000, 2500, 2500, 8192, 2000, 200));
        typed.push_back(0); exps.push_back(none);
        rows.push_back(make_pair(100, -100, 16384, 512, 1024, -300, 200, 32768, 512, 1024));
        typed.push_back(0); exps.push_back(none);
        rows.push_back(make_pair(8388607, 8388607, 65535, 65535, 0,
                                 8388607, 8388607, 49152, 0, 65535));
        typed.push_back(0); exps.push_back(none);
        rows.push_back(make_pair(-8388608, -8388608, 255, 1, 65535,
                                 -8388600, -8388608, 16383, 65535, 1));
        typed.push_back(0); exps.push_back(none);
        rows.push_back(make_pair(5000, 5000, 24576, 3000, 100, 7000, 4000, 40960, 3000, 100));
        typed.push_back(0); exps.push_back(none);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_pair(rows[i], typed[i], exps[i]);

        // Random part in three idling phases
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 36;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pair(random_pair(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (expected_hits.size() != 0)
            @(posedge clk);
        for (spare = 0; spare < 20; spare++)
            @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
